@@ design/tlnd_pkg.sv @@
`default_nettype none

package tlnd_pkg;

    // name width and the widest index / count the parameter range can need
    localparam int NAME_W = 64;
    localparam int IDX_W  = 6;   // up to 64 user cells
    localparam int CNT_W  = 7;   // counts 0..64

    // request codes (tuser on the input side)
    localparam logic [2:0] OP_CREATE_USER = 3'd0;
    localparam logic [2:0] OP_CREATE_FILE = 3'd1;
    localparam logic [2:0] OP_DELETE_FILE = 3'd2;
    localparam logic [2:0] OP_SEARCH_FILE = 3'd3;
    localparam logic [2:0] OP_LIST_FILES  = 3'd4;

    // status codes (tuser on the result side)
    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_USER_EXISTS    = 3'd1;
    localparam logic [2:0] ST_USER_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DIR_FULL       = 3'd3;
    localparam logic [2:0] ST_FILE_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_DIR_EMPTY      = 3'd5;
    localparam logic [2:0] ST_TABLE_FULL     = 3'd6;
    localparam logic [2:0] ST_UNUSED         = 3'd7;

    // lookup token walking the row of user cells
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  cnt;
        logic [NAME_W-1:0] name;
    } tok_t;

    // update broadcast from the controller to the cells
    typedef struct packed {
        logic              we;
        logic              new_user;
        logic [IDX_W-1:0]  idx;
        logic [CNT_W-1:0]  cnt;
        logic [NAME_W-1:0] name;
    } cell_wr_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_USCAN,
        S_FSCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_LIST_RD,
        S_LIST_OUT,
        S_RESULT
    } state_t;

endpackage

`default_nettype wire

@@ design/two_level_name_directory_top.sv @@
// a lookup walks MAX_USER_DIRS cells, one per cycle; single-result requests show their
//   word after the walk, search and delete after the scan of the user's file names, and
//   list sends one word per file name, each read from the file name store first
// one request at a time, paced by the cell row walk and the one-read-per-cycle
//   file name store
// reset: aresetn synchronous active low, empties the user table and all directories
`default_nettype none

module two_level_name_directory_top
    import tlnd_pkg::*;
#(
    parameter int MAX_USER_DIRS      = 8,
    parameter int MAX_FILES_PER_USER = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // request words
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // user_name [63:0], file_name [127:64]
    input  wire logic [2:0]   s_tuser,   // op [2:0]
    // result words
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // listed_name [63:0]
    output logic [2:0]        m_tuser,   // status [2:0]
    output logic              m_tlast    // last word of the request
);

    // token row: entry 0 is fed by the controller, the last one returns to it
    tok_t     chain [MAX_USER_DIRS+1];
    cell_wr_t cell_wr;

    tlnd_ctrl #(
        .MAX_USER_DIRS      (MAX_USER_DIRS),
        .MAX_FILES_PER_USER (MAX_FILES_PER_USER)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .tok_head (chain[0]),
        .tok_tail (chain[MAX_USER_DIRS]),
        .cell_wr  (cell_wr)
    );

    // one cell per user entry, each holding a name, an in-use flag and a file count
    for (genvar i = 0; i < MAX_USER_DIRS; i++) begin : g_cell
        tlnd_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_i   (chain[i]),
            .wr_i    (cell_wr),
            .tok_o   (chain[i+1])
        );
    end

endmodule

`default_nettype wire

@@ design/tlnd_cell.sv @@
`default_nettype none

module tlnd_cell
    import tlnd_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire tok_t     tok_i,
    input  wire cell_wr_t wr_i,
    output tok_t          tok_o
);

    tok_t              tok_reg;
    tok_t              tok_next;
    logic              used_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NAME_W-1:0] name_reg;
    logic              wr_sel;

    assign wr_sel = wr_i.we && (wr_i.idx == IDX_W'(CELL_IDX));
    assign tok_o  = tok_reg;

    // first used cell with an equal name claims the token
    always_comb begin
        tok_next = tok_i;
        if (tok_i.valid && !tok_i.hit && used_reg && (name_reg == tok_i.name)) begin
            tok_next.hit = 1'b1;
            tok_next.idx = IDX_W'(CELL_IDX);
            tok_next.cnt = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg  <= '0;
            used_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            tok_reg <= tok_next;
            if (wr_sel) begin
                cnt_reg <= wr_i.cnt;
                if (wr_i.new_user) begin
                    used_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_sel && wr_i.new_user) begin
            name_reg <= wr_i.name;
        end
    end

endmodule

`default_nettype wire

@@ design/tlnd_ctrl.sv @@
`default_nettype none

module tlnd_ctrl
    import tlnd_pkg::*;
#(
    parameter int MAX_USER_DIRS      = 8,
    parameter int MAX_FILES_PER_USER = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast,
    output tok_t              tok_head,
    input  wire tok_t         tok_tail,
    output cell_wr_t          cell_wr
);

    localparam int DEPTH = MAX_USER_DIRS * MAX_FILES_PER_USER;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic [2:0]        op_reg, op_next;
    logic [NAME_W-1:0] uname_reg, uname_next;
    logic [NAME_W-1:0] fname_reg, fname_next;
    logic [IDX_W-1:0]  uidx_reg, uidx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]     base_reg, base_next;
    logic [CNT_W-1:0]  users_reg, users_next;
    logic [CNT_W-1:0]  rd_j_reg, rd_j_next;
    logic              cmp_v_reg, cmp_v_next;
    logic [CNT_W-1:0]  cmp_j_reg, cmp_j_next;
    logic [CNT_W-1:0]  hit_j_reg, hit_j_next;
    logic [2:0]        res_reg, res_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [63:0]       m_tdata_reg, m_tdata_next;
    logic [2:0]        m_tuser_reg, m_tuser_next;
    logic              m_tlast_reg, m_tlast_next;

    // file name store
    logic [NAME_W-1:0] mem [DEPTH];
    logic [NAME_W-1:0] mem_rd_reg;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [NAME_W-1:0] wr_data;

    logic          accept, op_ok, out_free, uscan_done;
    logic [AW-1:0] tail_base;
    logic          scan_rd, scan_match, scan_end, list_last;

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign op_ok      = (s_tuser <= OP_LIST_FILES);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign uscan_done = (state_reg == S_USCAN) && tok_tail.valid;
    assign tail_base  = AW'(int'(tok_tail.idx) * MAX_FILES_PER_USER);
    assign scan_rd    = (rd_j_reg < cnt_reg);
    assign scan_match = cmp_v_reg && (mem_rd_reg == fname_reg);
    assign scan_end   = cmp_v_reg && (cmp_j_reg == cnt_reg - CNT_W'(1));
    assign list_last  = (rd_j_reg == cnt_reg - CNT_W'(1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && op_ok) begin
                    state_next = S_USCAN;
                end
            end
            S_USCAN: begin
                if (uscan_done) begin
                    state_next = S_RESULT;
                    if (tok_tail.hit && tok_tail.cnt != '0) begin
                        if (op_reg == OP_DELETE_FILE || op_reg == OP_SEARCH_FILE) begin
                            state_next = S_FSCAN;
                        end else if (op_reg == OP_LIST_FILES) begin
                            state_next = S_LIST_RD;
                        end
                    end
                end
            end
            S_FSCAN: begin
                if (scan_match) begin
                    state_next = (op_reg == OP_DELETE_FILE) ? S_MOVE_RD : S_RESULT;
                end else if (scan_end) begin
                    state_next = S_RESULT;
                end
            end
            S_MOVE_RD:  state_next = S_MOVE_WR;
            S_MOVE_WR:  state_next = S_RESULT;
            S_LIST_RD:  state_next = S_LIST_OUT;
            S_LIST_OUT: begin
                if (out_free) begin
                    state_next = list_last ? S_IDLE : S_LIST_RD;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        op_next       = op_reg;
        uname_next    = uname_reg;
        fname_next    = fname_reg;
        uidx_next     = uidx_reg;
        cnt_next      = cnt_reg;
        base_next     = base_reg;
        users_next    = users_reg;
        rd_j_next     = rd_j_reg;
        cmp_v_next    = 1'b0;
        cmp_j_next    = cmp_j_reg;
        hit_j_next    = hit_j_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        rd_en         = 1'b0;
        rd_addr       = base_reg;
        wr_en         = 1'b0;
        wr_addr       = base_reg;
        wr_data       = mem_rd_reg;
        tok_head      = '0;
        cell_wr       = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept && op_ok) begin
                    op_next        = s_tuser;
                    uname_next     = s_tdata[63:0];
                    fname_next     = s_tdata[127:64];
                    tok_head.valid = 1'b1;
                    tok_head.name  = s_tdata[63:0];
                end
            end
            S_USCAN: begin
                if (uscan_done) begin
                    uidx_next = tok_tail.idx;
                    cnt_next  = tok_tail.cnt;
                    base_next = tail_base;
                    rd_j_next = '0;
                    if (op_reg == OP_CREATE_USER) begin
                        if (tok_tail.hit) begin
                            res_next = ST_USER_EXISTS;
                        end else if (users_reg == CNT_W'(MAX_USER_DIRS)) begin
                            res_next = ST_TABLE_FULL;
                        end else begin
                            res_next         = ST_OK;
                            users_next       = users_reg + CNT_W'(1);
                            cell_wr.we       = 1'b1;
                            cell_wr.new_user = 1'b1;
                            cell_wr.idx      = IDX_W'(users_reg);
                            cell_wr.cnt      = '0;
                            cell_wr.name     = uname_reg;
                        end
                    end else if (!tok_tail.hit) begin
                        res_next = ST_USER_NOT_FOUND;
                    end else if (op_reg == OP_CREATE_FILE) begin
                        if (tok_tail.cnt == CNT_W'(MAX_FILES_PER_USER)) begin
                            res_next = ST_DIR_FULL;
                        end else begin
                            res_next    = ST_OK;
                            wr_en       = 1'b1;
                            wr_addr     = tail_base + AW'(tok_tail.cnt);
                            wr_data     = fname_reg;
                            cell_wr.we  = 1'b1;
                            cell_wr.idx = tok_tail.idx;
                            cell_wr.cnt = tok_tail.cnt + CNT_W'(1);
                        end
                    end else if (op_reg == OP_LIST_FILES) begin
                        res_next = ST_DIR_EMPTY;
                    end else begin
                        res_next = ST_FILE_NOT_FOUND;
                    end
                end
            end
            S_FSCAN: begin
                // read slot rd_j while comparing the slot read in the previous cycle
                if (scan_rd) begin
                    rd_en      = 1'b1;
                    rd_addr    = base_reg + AW'(rd_j_reg);
                    rd_j_next  = rd_j_reg + CNT_W'(1);
                    cmp_v_next = !scan_match && !scan_end;
                    cmp_j_next = rd_j_reg;
                end
                if (scan_match) begin
                    res_next   = ST_OK;
                    hit_j_next = cmp_j_reg;
                end else if (scan_end) begin
                    res_next = ST_FILE_NOT_FOUND;
                end
            end
            S_MOVE_RD: begin
                rd_en   = 1'b1;
                rd_addr = base_reg + AW'(cnt_reg - CNT_W'(1));
            end
            S_MOVE_WR: begin
                wr_en       = 1'b1;
                wr_addr     = base_reg + AW'(hit_j_reg);
                wr_data     = mem_rd_reg;
                cell_wr.we  = 1'b1;
                cell_wr.idx = uidx_reg;
                cell_wr.cnt = cnt_reg - CNT_W'(1);
            end
            S_LIST_RD: begin
                rd_en   = 1'b1;
                rd_addr = base_reg + AW'(rd_j_reg);
            end
            S_LIST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ST_OK;
                    m_tdata_next  = mem_rd_reg;
                    m_tlast_next  = list_last;
                    rd_j_next     = rd_j_reg + CNT_W'(1);
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_reg;
                    m_tdata_next  = '0;
                    m_tlast_next  = 1'b1;
                end
            end
            default: begin
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            users_reg    <= '0;
            cmp_v_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            users_reg    <= users_next;
            cmp_v_reg    <= cmp_v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        uname_reg   <= uname_next;
        fname_reg   <= fname_next;
        uidx_reg    <= uidx_next;
        cnt_reg     <= cnt_next;
        base_reg    <= base_next;
        rd_j_reg    <= rd_j_next;
        cmp_j_reg   <= cmp_j_next;
        hit_j_reg   <= hit_j_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/tlnd_checker.sv @@
`default_nettype none

module tlnd_checker
    import tlnd_pkg::*;
(
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [63:0]  m_tdata,
    input wire logic [2:0]   m_tuser,
    input wire logic         m_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    // any non-ok status is a single, final word
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> m_tlast)
        else $error("error status without last");

    // words with an error status carry no name
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("error status with a name");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != ST_UNUSED))
        else $error("undefined status code");

endmodule

bind two_level_name_directory_top tlnd_checker u_tlnd_checker (.*);

`default_nettype wire
